// ===== hw/rtl/ohlcv_pkg.sv =====
`default_nettype none

package ohlcv_pkg;

  localparam int unsigned ETYPE_W = 8;
  localparam int unsigned TS_W    = 57;
  localparam int unsigned PX_W    = 31;
  localparam int unsigned QTY_W   = 40;
  localparam int unsigned KEY_W   = 47;
  localparam int unsigned VOL_W   = 48;
  localparam int unsigned TURN_W  = 63;
  localparam int unsigned CNT_W   = 24;
  localparam int unsigned SEC_W   = 20;
  localparam int unsigned CFG_W   = 20;
  localparam int unsigned CFG_IDX_W = 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_START_SEC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_SEC   = 1'b1;

  // Command codes.
  localparam logic CMD_EXEC  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [ETYPE_W-1:0] FILL_CHAR = 8'd70;

  // The day is (ts >> 9) / 5^9. The estimate uses ts[56:29] and a 2^50 reciprocal;
  // it is low by at most one and is fixed with one compare and subtract.
  localparam logic [20:0] DAY_DIV   = 21'd1953125;
  localparam logic [29:0] DAY_RECIP = 30'd576460752;

  // Second of day is ((r << 6) + ts[8:3]) / 125, exact with a 2^34 reciprocal.
  localparam logic [27:0] SEC_RECIP = 28'd137438954;

  localparam logic [19:0] KEY_SCALE = 20'd1000000;

  // Volume is qty / 100 in two 20-bit digits, each exact by reciprocal.
  localparam logic [6:0]  VOL_DIV      = 7'd100;
  localparam logic [20:0] VOL_RECIP_HI = 21'd1342178;
  localparam logic [27:0] VOL_RECIP_LO = 28'd171798692;

endpackage

`default_nettype wire

// ===== hw/rtl/ohlcv_second_bar_aggregator.sv =====
`default_nettype none

// One-second OHLCV bar builder. It takes one execution record or flush command per
// cycle and can take a new one in every cycle, also in the cycle in which a finished
// bar is taken from the output register; it stalls only when that register is full
// and not being taken. A transaction that closes a bar passes the input register and
// five pipeline stages, which split the timestamp, form qty/100 and the saturated
// price times quantity; the bar stage then updates the open bar and loads the output
// register with the finished bar.
// Only fills whose second of day lies inside the configured window count; a fill with
// a new second first emits the open bar, and a flush emits any open bar. The user must
// write configuration only while no transaction is in flight; it is not enforced.
module ohlcv_second_bar_aggregator (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,

  input  wire logic                           cfg_we_i,
  input  wire logic [ohlcv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ohlcv_pkg::CFG_W-1:0]     cfg_wdata_i,

  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           cmd_i,
  input  wire logic [ohlcv_pkg::ETYPE_W-1:0]   exec_type_i,
  input  wire logic [ohlcv_pkg::TS_W-1:0]      transact_time_i,
  input  wire logic [ohlcv_pkg::PX_W-1:0]      trade_price_i,
  input  wire logic [ohlcv_pkg::QTY_W-1:0]     trade_qty_i,

  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [ohlcv_pkg::KEY_W-1:0]          bar_time_key_o,
  output logic [ohlcv_pkg::PX_W-1:0]           bar_open_o,
  output logic [ohlcv_pkg::PX_W-1:0]           bar_high_o,
  output logic [ohlcv_pkg::PX_W-1:0]           bar_low_o,
  output logic [ohlcv_pkg::PX_W-1:0]           bar_close_o,
  output logic [ohlcv_pkg::VOL_W-1:0]          bar_volume_o,
  output logic [ohlcv_pkg::TURN_W-1:0]         bar_turnover_o,
  output logic [ohlcv_pkg::CNT_W-1:0]          bar_trades_o
);
  import ohlcv_pkg::*;

  // Configuration.
  logic [SEC_W-1:0] start_q, end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_SEC: start_q <= cfg_wdata_i;
        CFG_END_SEC:   end_q   <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  // The whole pipeline moves when the output register is free or being drained.
  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  logic v_a_q, v_b_q, v_c_q, v_d_q, v_e_q, v_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
      v_e_q <= 1'b0;
      v_f_q <= 1'b0;
    end else if (en) begin
      v_a_q <= in_valid_i;
      v_b_q <= v_a_q;
      v_c_q <= v_b_q;
      v_d_q <= v_c_q;
      v_e_q <= v_d_q;
      v_f_q <= v_e_q;
    end
  end

  // Stage A: input register.
  logic              cmd_a_q, fill_a_q;
  logic [TS_W-1:3]   ts_a_q;
  logic [PX_W-1:0]   px_a_q;
  logic [QTY_W-1:0]  qty_a_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd_a_q  <= cmd_i;
      fill_a_q <= (exec_type_i == FILL_CHAR);
      ts_a_q   <= transact_time_i[TS_W-1:3];
      px_a_q   <= trade_price_i;
      qty_a_q  <= trade_qty_i;
    end
  end

  // Stage B: day estimate, turnover partial products, high volume digit.
  logic [57:0] qe_prod;
  logic [62:0] turn_lo_prod;
  logic [38:0] turn_hi_prod;
  logic [40:0] vola_prod;

  assign qe_prod      = 58'(ts_a_q[56:29]) * 58'(DAY_RECIP);
  assign turn_lo_prod = 63'(px_a_q) * 63'(qty_a_q[31:0]);
  assign turn_hi_prod = 39'(px_a_q) * 39'(qty_a_q[39:32]);
  assign vola_prod    = 41'(qty_a_q[39:20]) * 41'(VOL_RECIP_HI);

  logic              cmd_b_q, fill_b_q;
  logic [27:0]       qe_b_q;
  logic [21:0]       n_b_q;
  logic [5:0]        low_b_q;
  logic [62:0]       turn_lo_b_q;
  logic [38:0]       turn_hi_b_q;
  logic [13:0]       vola_b_q;
  logic [19:0]       qh_b_q, ql_b_q;
  logic [PX_W-1:0]   px_b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd_b_q     <= cmd_a_q;
      fill_b_q    <= fill_a_q;
      qe_b_q      <= qe_prod[57:30];
      n_b_q       <= ts_a_q[30:9];
      low_b_q     <= ts_a_q[8:3];
      turn_lo_b_q <= turn_lo_prod;
      turn_hi_b_q <= turn_hi_prod;
      vola_b_q    <= vola_prod[40:27];
      qh_b_q      <= qty_a_q[39:20];
      ql_b_q      <= qty_a_q[19:0];
      px_b_q      <= px_a_q;
    end
  end

  // Stage C: back-multiply the day estimate, sum and clamp the turnover,
  // remainder of the high volume digit.
  logic [48:0] qd_prod;
  logic [71:0] turn_sum;
  logic [19:0] vola_x100;

  assign qd_prod   = 49'(qe_b_q) * 49'(DAY_DIV);
  assign turn_sum  = 72'(turn_lo_b_q) + 72'({turn_hi_b_q, 32'd0});
  assign vola_x100 = 20'(vola_b_q) * 20'(VOL_DIV);

  logic              cmd_c_q, fill_c_q;
  logic [27:0]       qe_c_q;
  logic [21:0]       n_c_q, qd_c_q;
  logic [5:0]        low_c_q;
  logic [TURN_W-1:0] turn_c_q;
  logic [13:0]       vola_c_q;
  logic [6:0]        ra_c_q;
  logic [19:0]       ql_c_q;
  logic [PX_W-1:0]   px_c_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd_c_q  <= cmd_b_q;
      fill_c_q <= fill_b_q;
      qe_c_q   <= qe_b_q;
      n_c_q    <= n_b_q;
      qd_c_q   <= qd_prod[21:0];
      low_c_q  <= low_b_q;
      turn_c_q <= (|turn_sum[71:63]) ? '1 : turn_sum[62:0];
      vola_c_q <= vola_b_q;
      ra_c_q   <= 7'(qh_b_q - vola_x100);
      ql_c_q   <= ql_b_q;
      px_c_q   <= px_b_q;
    end
  end

  // Stage D: day remainder with its single correction, low volume digit.
  // The remainder below 2^22 is all that matters, so only those bits are kept.
  logic [21:0] r_raw;
  logic        r_corr;
  logic [54:0] volb_prod;

  assign r_raw     = n_c_q - qd_c_q;
  assign r_corr    = (r_raw >= 22'(DAY_DIV));
  assign volb_prod = 55'({ra_c_q, ql_c_q}) * 55'(VOL_RECIP_LO);

  logic              cmd_d_q, fill_d_q;
  logic [27:0]       day_d_q;
  logic [20:0]       r_d_q;
  logic [5:0]        low_d_q;
  logic [TURN_W-1:0] turn_d_q;
  logic [13:0]       vola_d_q;
  logic [19:0]       volb_d_q;
  logic [PX_W-1:0]   px_d_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd_d_q  <= cmd_c_q;
      fill_d_q <= fill_c_q;
      day_d_q  <= qe_c_q + 28'(r_corr);
      r_d_q    <= 21'(r_corr ? (r_raw - 22'(DAY_DIV)) : r_raw);
      low_d_q  <= low_c_q;
      turn_d_q <= turn_c_q;
      vola_d_q <= vola_c_q;
      volb_d_q <= volb_prod[53:34];
      px_d_q   <= px_c_q;
    end
  end

  // Stage E: second of day and the scaled day.
  logic [54:0] sec_prod;
  logic [47:0] dk_prod;

  assign sec_prod = 55'({r_d_q, low_d_q}) * 55'(SEC_RECIP);
  assign dk_prod  = 48'(day_d_q) * 48'(KEY_SCALE);

  logic              cmd_e_q, fill_e_q;
  logic [SEC_W-1:0]  sec_e_q;
  logic [KEY_W-1:0]  dk_e_q;
  logic [TURN_W-1:0] turn_e_q;
  logic [33:0]       vol_e_q;
  logic [PX_W-1:0]   px_e_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd_e_q  <= cmd_d_q;
      fill_e_q <= fill_d_q;
      sec_e_q  <= sec_prod[53:34];
      dk_e_q   <= dk_prod[KEY_W-1:0];
      turn_e_q <= turn_d_q;
      vol_e_q  <= {vola_d_q, volb_d_q};
      px_e_q   <= px_d_q;
    end
  end

  // Stage F: bar key and time window.
  logic              cmd_f_q, trade_f_q;
  logic [KEY_W-1:0]  key_f_q;
  logic [TURN_W-1:0] turn_f_q;
  logic [33:0]       vol_f_q;
  logic [PX_W-1:0]   px_f_q;
  logic              in_win;

  assign in_win = (sec_e_q >= start_q) && ((end_q == '0) || (sec_e_q <= end_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd_f_q   <= cmd_e_q;
      trade_f_q <= fill_e_q && in_win;
      key_f_q   <= dk_e_q + KEY_W'(sec_e_q);
      turn_f_q  <= turn_e_q;
      vol_f_q   <= vol_e_q;
      px_f_q    <= px_e_q;
    end
  end

  // Bar stage.
  logic              bar_open_q;
  logic [KEY_W-1:0]  key_q;
  logic [PX_W-1:0]   open_q, high_q, low_q, close_q;
  logic [VOL_W-1:0]  vol_q;
  logic [TURN_W-1:0] turn_q;
  logic [CNT_W-1:0]  cnt_q;

  logic              do_flush, do_trade, new_key, fresh, emit;
  logic [VOL_W:0]    vol_sum;
  logic [TURN_W:0]   turn_sum2;
  logic [CNT_W:0]    cnt_sum;
  logic [PX_W-1:0]   open_d, high_d, low_d;
  logic [VOL_W-1:0]  vol_d;
  logic [TURN_W-1:0] turn_d;
  logic [CNT_W-1:0]  cnt_d;

  always_comb begin
    do_flush  = en && v_f_q && (cmd_f_q == CMD_FLUSH);
    do_trade  = en && v_f_q && (cmd_f_q == CMD_EXEC) && trade_f_q;
    new_key   = bar_open_q && (key_f_q != key_q);
    fresh     = !bar_open_q || new_key;
    emit      = (do_flush && bar_open_q) || (do_trade && new_key);

    vol_sum   = {1'b0, vol_q} + (VOL_W + 1)'(vol_f_q);
    turn_sum2 = {1'b0, turn_q} + (TURN_W + 1)'(turn_f_q);
    cnt_sum   = {1'b0, cnt_q} + (CNT_W + 1)'(1);

    if (fresh) begin
      open_d = px_f_q;
      high_d = px_f_q;
      low_d  = px_f_q;
      vol_d  = VOL_W'(vol_f_q);
      turn_d = turn_f_q;
      cnt_d  = CNT_W'(1);
    end else begin
      open_d = open_q;
      high_d = (px_f_q > high_q) ? px_f_q : high_q;
      low_d  = (px_f_q < low_q) ? px_f_q : low_q;
      vol_d  = vol_sum[VOL_W] ? '1 : vol_sum[VOL_W-1:0];
      turn_d = turn_sum2[TURN_W] ? '1 : turn_sum2[TURN_W-1:0];
      cnt_d  = cnt_sum[CNT_W] ? '1 : cnt_sum[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_open_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (do_flush) begin
        bar_open_q <= 1'b0;
      end else if (do_trade) begin
        bar_open_q <= 1'b1;
      end
      if (en) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_trade) begin
      key_q   <= key_f_q;
      open_q  <= open_d;
      high_q  <= high_d;
      low_q   <= low_d;
      close_q <= px_f_q;
      vol_q   <= vol_d;
      turn_q  <= turn_d;
      cnt_q   <= cnt_d;
    end
  end

  // Output register, loaded with the bar as it stood before this transaction.
  logic [KEY_W-1:0]  out_key_q;
  logic [PX_W-1:0]   out_open_q, out_high_q, out_low_q, out_close_q;
  logic [VOL_W-1:0]  out_vol_q;
  logic [TURN_W-1:0] out_turn_q;
  logic [CNT_W-1:0]  out_cnt_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_key_q   <= key_q;
      out_open_q  <= open_q;
      out_high_q  <= high_q;
      out_low_q   <= low_q;
      out_close_q <= close_q;
      out_vol_q   <= vol_q;
      out_turn_q  <= turn_q;
      out_cnt_q   <= cnt_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign bar_time_key_o = out_key_q;
  assign bar_open_o     = out_open_q;
  assign bar_high_o     = out_high_q;
  assign bar_low_o      = out_low_q;
  assign bar_close_o    = out_close_q;
  assign bar_volume_o   = out_vol_q;
  assign bar_turnover_o = out_turn_q;
  assign bar_trades_o   = out_cnt_q;

  // An open bar keeps its open and close prices between its low and high.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bar_open_q |-> (low_q <= open_q) && (open_q <= high_q) &&
                   (low_q <= close_q) && (close_q <= high_q))
    else $error("open bar prices out of order");

  // Every bar that is open or delivered holds at least one fill.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bar_open_q |-> cnt_q != '0) and (out_valid_q |-> out_cnt_q != '0))
    else $error("bar with no trades");

  // One correction step must bring the day remainder below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_d_q |-> (r_d_q < DAY_DIV))
    else $error("day remainder not reduced");

  // The second of day taken from the remainder stays below one million.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_e_q |-> (sec_e_q < KEY_SCALE))
    else $error("second of day out of range");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ohlcv_pkg::*;

  localparam longint unsigned TS_DAY_DIV  = 64'd1000000000;
  localparam longint unsigned TS_SEC_DIV  = 64'd1000;
  localparam longint unsigned KEY_SEC_MUL = 64'd1000000;
  localparam int unsigned     SEC_MAX     = 999999;
  localparam int unsigned     CFG_SETTLE  = 12;
  localparam int unsigned     NUM_PHASES  = 6;

  localparam logic [ETYPE_W-1:0] ETYPE_TRADE_CANCEL = 8'd69;
  localparam logic [ETYPE_W-1:0] ETYPE_ALL_ONES     = 8'hFF;

  localparam logic [TS_W-1:0]   TS_MAX   = '1;
  localparam logic [PX_W-1:0]   PX_MAX   = '1;
  localparam logic [QTY_W-1:0]  QTY_MAX  = '1;
  localparam logic [VOL_W-1:0]  VOL_MAX  = '1;
  localparam logic [TURN_W-1:0] TURN_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  typedef struct packed {
    logic               cmd;
    logic [ETYPE_W-1:0] etype;
    logic [TS_W-1:0]    ts;
    logic [PX_W-1:0]    px;
    logic [QTY_W-1:0]   qty;
  } trade_rec_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [PX_W-1:0]   px_open;
    logic [PX_W-1:0]   px_high;
    logic [PX_W-1:0]   px_low;
    logic [PX_W-1:0]   px_close;
    logic [VOL_W-1:0]  vol;
    logic [TURN_W-1:0] turn;
    logic [CNT_W-1:0]  trades;
  } bar_t;

  typedef enum bit {ROW_REC, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_W-1:0]         val;
    trade_rec_t               rec;
    bit                       typed;
    bar_t                     bar;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic                 cmd_i           = 1'b0;
  logic [ETYPE_W-1:0]   exec_type_i     = '0;
  logic [TS_W-1:0]      transact_time_i = '0;
  logic [PX_W-1:0]      trade_price_i   = '0;
  logic [QTY_W-1:0]     trade_qty_i     = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [KEY_W-1:0]     bar_time_key_o;
  logic [PX_W-1:0]      bar_open_o;
  logic [PX_W-1:0]      bar_high_o;
  logic [PX_W-1:0]      bar_low_o;
  logic [PX_W-1:0]      bar_close_o;
  logic [VOL_W-1:0]     bar_volume_o;
  logic [TURN_W-1:0]    bar_turnover_o;
  logic [CNT_W-1:0]     bar_trades_o;

  ohlcv_second_bar_aggregator uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .exec_type_i     (exec_type_i),
    .transact_time_i (transact_time_i),
    .trade_price_i   (trade_price_i),
    .trade_qty_i     (trade_qty_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .bar_time_key_o  (bar_time_key_o),
    .bar_open_o      (bar_open_o),
    .bar_high_o      (bar_high_o),
    .bar_low_o       (bar_low_o),
    .bar_close_o     (bar_close_o),
    .bar_volume_o    (bar_volume_o),
    .bar_turnover_o  (bar_turnover_o),
    .bar_trades_o    (bar_trades_o)
  );

  // Shadow copy of the window registers and of the bar being built.
  logic [SEC_W-1:0]  win_start = '0;
  logic [SEC_W-1:0]  win_end   = '0;
  bit                bar_live  = 1'b0;
  logic [KEY_W-1:0]  live_key   = '0;
  logic [PX_W-1:0]   live_open  = '0;
  logic [PX_W-1:0]   live_high  = '0;
  logic [PX_W-1:0]   live_low   = '0;
  logic [PX_W-1:0]   live_close = '0;
  logic [VOL_W-1:0]  live_vol   = '0;
  logic [TURN_W-1:0] live_turn  = '0;
  logic [CNT_W-1:0]  live_cnt   = '0;

  bar_t        pending_bars[$];
  dir_row_t    rows[$];
  bit          gaps_on    = 1'b1;
  int unsigned mismatches = 0;
  int unsigned n_sent     = 0;
  int unsigned n_bars     = 0;
  int unsigned n_cfg      = 0;
  int unsigned gen_day    = 20240102;
  int unsigned gen_sec    = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("[ohlcv_second_bar_aggregator] ERROR");
    $finish;
  end

  function automatic logic [TS_W-1:0] stamp(input longint unsigned day, input longint unsigned sec,
                                            input longint unsigned ms);
    logic [63:0] v;
    v = day * TS_DAY_DIV + sec * TS_SEC_DIV + ms;
    return v[TS_W-1:0];
  endfunction

  function automatic bar_t close_bar();
    bar_t b;
    b = '{live_key, live_open, live_high, live_low, live_close, live_vol, live_turn, live_cnt};
    bar_live   = 1'b0;
    live_key   = '0;
    live_open  = '0;
    live_high  = '0;
    live_low   = '0;
    live_close = '0;
    live_vol   = '0;
    live_turn  = '0;
    live_cnt   = '0;
    return b;
  endfunction

  // Applies one transaction to the shadow bar; returns 1 when a finished bar comes out.
  function automatic bit advance_bar(input trade_rec_t r, output bar_t closed);
    longint unsigned             day;
    longint unsigned             sec;
    logic [63:0]                 key64;
    logic [KEY_W-1:0]            key;
    logic [PX_W+QTY_W-1:0]       prod;
    logic [TURN_W-1:0]           prod_sat;
    logic [VOL_W:0]              vsum;
    logic [TURN_W:0]             tsum;
    bit                          emitted;
    emitted = 1'b0;
    closed  = '0;
    if (r.cmd == CMD_FLUSH) begin
      if (!bar_live) return 1'b0;
      closed = close_bar();
      return 1'b1;
    end
    if (r.etype != FILL_CHAR) return 1'b0;
    day = r.ts / TS_DAY_DIV;
    sec = (r.ts % TS_DAY_DIV) / TS_SEC_DIV;
    if (sec < win_start) return 1'b0;
    if (win_end != 0 && sec > win_end) return 1'b0;
    key64 = day * KEY_SEC_MUL + sec;
    key = key64[KEY_W-1:0];

    if (bar_live && live_key != key) begin
      closed  = close_bar();
      emitted = 1'b1;
    end
    if (!bar_live) begin
      bar_live   = 1'b1;
      live_key   = key;
      live_open  = r.px;
      live_high  = r.px;
      live_low   = r.px;
      live_close = r.px;
    end else begin
      if (r.px > live_high) live_high = r.px;
      if (r.px < live_low) live_low = r.px;
      live_close = r.px;
    end

    vsum = live_vol + r.qty / VOL_DIV;
    live_vol = vsum[VOL_W] ? VOL_MAX : vsum[VOL_W-1:0];
    prod = r.px * r.qty;
    prod_sat = (prod > TURN_MAX) ? TURN_MAX : prod[TURN_W-1:0];
    tsum = live_turn + prod_sat;
    live_turn = tsum[TURN_W] ? TURN_MAX : tsum[TURN_W-1:0];
    if (live_cnt != CNT_MAX) live_cnt = live_cnt + 1'b1;
    return emitted;
  endfunction

  function automatic dir_row_t rec_row(input logic c, input logic [ETYPE_W-1:0] et,
                                       input logic [TS_W-1:0] ts, input logic [PX_W-1:0] px,
                                       input logic [QTY_W-1:0] qty);
    dir_row_t d;
    d.kind  = ROW_REC;
    d.idx   = '0;
    d.val   = '0;
    d.rec   = '{c, et, ts, px, qty};
    d.typed = 1'b0;
    d.bar   = '0;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    dir_row_t d;
    d = rec_row(CMD_EXEC, '0, '0, '0, '0);
    d.kind = ROW_CFG;
    d.idx  = idx;
    d.val  = val;
    return d;
  endfunction

  function automatic dir_row_t checked(input dir_row_t d, input bar_t b);
    d.typed = 1'b1;
    d.bar   = b;
    return d;
  endfunction

  function automatic void add_row(input dir_row_t d);
    rows.insert(rows.size(), d);
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("bar %0d, %s: expected %0d, got %0d", n_bars, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_bar();
    bar_t want;
    bar_t got;
    got = '{bar_time_key_o, bar_open_o, bar_high_o, bar_low_o, bar_close_o, bar_volume_o,
            bar_turnover_o, bar_trades_o};
    if (pending_bars.size() == 0) begin
      if (mismatches < 10) $display("unexpected bar with key %0d", got.key);
      mismatches++;
    end else begin
      want = pending_bars.pop_front();
      check_field("bar key", want.key, got.key);
      check_field("open", want.px_open, got.px_open);
      check_field("high", want.px_high, got.px_high);
      check_field("low", want.px_low, got.px_low);
      check_field("close", want.px_close, got.px_close);
      check_field("volume", want.vol, got.vol);
      check_field("turnover", want.turn, got.turn);
      check_field("trades", want.trades, got.trades);
      n_bars++;
    end
  endtask

  // Sampling at the edge sees pre-edge values, so this is the handshake itself.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_bar();
    out_ready_i <= !(gaps_on && $urandom_range(0, 99) < 34);
  end

  task automatic drive_txn(input trade_rec_t r, input bit typed, input bar_t typed_bar);
    bar_t b;
    bit   closes;
    while (gaps_on && $urandom_range(0, 99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= r.cmd;
    exec_type_i     <= r.etype;
    transact_time_i <= r.ts;
    trade_price_i   <= r.px;
    trade_qty_i     <= r.qty;
    do @(posedge clk_i); while (!in_ready_o);
    closes = advance_bar(r, b);
    if (typed) pending_bars.insert(pending_bars.size(), typed_bar);
    else if (closes) pending_bars.insert(pending_bars.size(), b);
    n_sent++;
  endtask

  task automatic wait_for_bars();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_bars.size() != 0);
  endtask

  // Fills and ignored records leave no trace on the output, so give the pipeline time
  // to empty before touching the window registers.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wait_for_bars();
    repeat (CFG_SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_START_SEC) win_start = val;
    else win_end = val;
    n_cfg++;
  endtask

  // Mostly fills that walk forward second by second inside the window, with flushes,
  // other execution types, raw timestamps and out-of-window fills mixed in.
  task automatic gen_trade(output trade_rec_t r);
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    int unsigned sec;
    logic [63:0] rnd_a;
    logic [63:0] rnd_b;
    logic [63:0] rnd_c;
    pick  = $urandom_range(0, 99);
    lo    = win_start;
    hi    = (win_end == 0) ? SEC_MAX : win_end;
    rnd_a = {$urandom(), $urandom()};
    rnd_b = {$urandom(), $urandom()};
    rnd_c = {$urandom(), $urandom()};
    r.cmd   = CMD_EXEC;
    r.etype = FILL_CHAR;
    r.px    = ($urandom_range(0, 9) == 0) ? rnd_a[PX_W-1:0]
                                          : PX_W'($urandom_range(900000, 1100000));
    r.qty   = ($urandom_range(0, 9) == 0) ? rnd_b[QTY_W-1:0]
                                          : QTY_W'($urandom_range(0, 500000));
    if (pick < 5) begin
      r.cmd   = CMD_FLUSH;
      r.etype = rnd_c[ETYPE_W-1:0];
      r.ts    = rnd_c[TS_W-1:0];
    end else if (pick < 12) begin
      r.etype = rnd_c[ETYPE_W-1:0];
      r.ts    = stamp(gen_day, gen_sec, $urandom_range(0, 999));
    end else if (pick < 17) begin
      r.ts = rnd_c[TS_W-1:0];
    end else if (pick < 24 && (lo > 0 || hi < SEC_MAX)) begin
      if (lo > 0 && (hi == SEC_MAX || $urandom_range(0, 1) == 0)) sec = $urandom_range(0, lo - 1);
      else sec = $urandom_range(hi + 1, SEC_MAX);
      r.ts = stamp(gen_day, sec, $urandom_range(0, 999));
    end else begin
      if ($urandom_range(0, 49) == 0) begin
        gen_day = $urandom_range(0, 99999999);
      end else if ($urandom_range(0, 99) < 30) begin
        if (gen_sec >= hi) begin
          gen_day++;
          gen_sec = lo;
        end else begin
          gen_sec++;
        end
      end
      r.ts = stamp(gen_day, gen_sec, $urandom_range(0, 999));
    end
  endtask

  initial begin
    int unsigned ph_lo[NUM_PHASES];
    int unsigned ph_hi[NUM_PHASES];
    int unsigned ph_n[NUM_PHASES];
    int unsigned n_directed;
    logic [63:0] day_d;
    trade_rec_t  r;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    day_d = 64'd20240102;
    add_row(rec_row(CMD_FLUSH, '0, '0, '0, '0));
    add_row(rec_row(CMD_EXEC, ETYPE_TRADE_CANCEL, stamp(day_d, 93000, 0),
                    31'd1000000, 40'd10000));
    add_row(rec_row(CMD_EXEC, FILL_CHAR, '0, '0, '0));
    add_row(checked(rec_row(CMD_FLUSH, '0, '0, '0, '0), '{'0, '0, '0, '0, '0, '0, '0, 24'd1}));
    add_row(rec_row(CMD_EXEC, FILL_CHAR, TS_MAX, PX_MAX, QTY_MAX));
    // The all-ones timestamp gives a key beyond 47 bits, which wraps.
    add_row(checked(rec_row(CMD_FLUSH, '0, '0, '0, '0),
                    '{47'd3377699720527, PX_MAX, PX_MAX, PX_MAX, PX_MAX,
                      48'd10995116277, TURN_MAX, 24'd1}));
    add_row(rec_row(CMD_EXEC, FILL_CHAR, 57'd99999999999999999, 31'd5, 40'd99));
    add_row(rec_row(CMD_EXEC, FILL_CHAR, 57'd99999999999999000, 31'd7, 40'd100));
    add_row(rec_row(CMD_EXEC, ETYPE_ALL_ONES, 57'd99999999999999500, 31'd1, 40'd1));
    add_row(checked(rec_row(CMD_EXEC, FILL_CHAR, stamp(day_d, 93000, 500), 31'd3, 40'd250),
                    '{47'd99999999999999, 31'd5, 31'd7, 31'd5, 31'd7, 48'd1,
                      63'd1195, 24'd2}));
    add_row(rec_row(CMD_EXEC, FILL_CHAR, stamp(day_d, 93000, 600), 31'd2, 40'd12345));
    add_row(rec_row(CMD_EXEC, FILL_CHAR, stamp(day_d, 93000, 700), 31'd9, 40'd1));
    add_row(rec_row(CMD_EXEC, FILL_CHAR, stamp(day_d, 93000, 800), PX_MAX, 40'h1_0000_0000));
    add_row(rec_row(CMD_EXEC, FILL_CHAR, stamp(day_d, 93000, 999), PX_MAX, 40'h1_0000_0000));
    // A flush ignores its other fields.
    add_row(rec_row(CMD_FLUSH, FILL_CHAR, stamp(day_d, 93001, 0), 31'd77, 40'd77));
    add_row(rec_row(CMD_FLUSH, '0, '0, '0, '0));
    add_row(cfg_row(CFG_START_SEC, 20'd93000));
    add_row(cfg_row(CFG_END_SEC, 20'd150000));
    add_row(rec_row(CMD_EXEC, FILL_CHAR, stamp(day_d, 92959, 999), 31'd100, 40'd100));
    add_row(rec_row(CMD_EXEC, FILL_CHAR, stamp(day_d, 93000, 0), 31'd200, 40'd300));
    // Past the end of the window: dropped without closing the open bar.
    add_row(rec_row(CMD_EXEC, FILL_CHAR, stamp(day_d, 150001, 0), 31'd300, 40'd300));
    add_row(rec_row(CMD_EXEC, FILL_CHAR, stamp(day_d, 150000, 999), 31'd400, 40'd500));
    add_row(rec_row(CMD_FLUSH, '0, '0, '0, '0));
    add_row(cfg_row(CFG_START_SEC, 20'd999999));
    add_row(cfg_row(CFG_END_SEC, 20'd0));
    add_row(rec_row(CMD_EXEC, FILL_CHAR, stamp(day_d, 999998, 0), 31'd10, 40'd1000));
    add_row(rec_row(CMD_EXEC, FILL_CHAR, stamp(day_d, 999999, 999), 31'd11, 40'd1000));
    add_row(rec_row(CMD_FLUSH, '0, '0, '0, '0));

    foreach (rows[k]) begin
      if (rows[k].kind == ROW_CFG) write_reg(rows[k].idx, rows[k].val);
      else drive_txn(rows[k].rec, rows[k].typed, rows[k].bar);
    end
    n_directed = n_sent;

    ph_lo[0] = 0;                         ph_hi[0] = 0;             ph_n[0] = 80;
    ph_lo[1] = 93000;                     ph_hi[1] = 150000;        ph_n[1] = 80;
    ph_lo[2] = $urandom_range(0, 200000); ph_hi[2] = ph_lo[2] + $urandom_range(0, 20);
    ph_n[2] = 80;
    ph_lo[3] = 0;                         ph_hi[3] = SEC_MAX;       ph_n[3] = 80;
    ph_lo[4] = SEC_MAX;                   ph_hi[4] = 0;             ph_n[4] = 40;
    ph_lo[5] = $urandom_range(1, 500000); ph_hi[5] = 0;             ph_n[5] = 40;

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_START_SEC, CFG_W'(ph_lo[p]));
      write_reg(CFG_END_SEC, CFG_W'(ph_hi[p]));
      gaps_on <= (p != 1);
      gen_sec = ph_lo[p];
      for (int i = 0; i < ph_n[p]; i++) begin
        if (i == ph_n[p] / 2) wait_for_bars();
        gen_trade(r);
        drive_txn(r, 1'b0, '0);
      end
    end

    wait_for_bars();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d transactions (%0d directed) over %0d register writes; checked %0d bars.",
             n_sent, n_directed, n_cfg, n_bars);
    $display("Windows ranged from fully open to a single second; %0d mismatches seen.",
             mismatches);
    if (mismatches == 0) begin
      $display("[ohlcv_second_bar_aggregator] OK");
    end else begin
      $display("[ohlcv_second_bar_aggregator] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ohlcv_pkg.sv
hw/rtl/ohlcv_second_bar_aggregator.sv
tb/tb_top.sv
